// File: design/rbp_pkg.sv
// Shared types and constants for the replicate border pad block.
`default_nettype none
package rbp_pkg;

   // Internal coordinate widths: hold width + 1 and height + 1
   localparam int COL_BITS = 12;
   localparam int ROW_BITS = 14;

   // Configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 13;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PIXEL_FORMAT = 2'd2;

   // Pixel format codes
   localparam logic [1:0] FMT_8  = 2'd0;
   localparam logic [1:0] FMT_16 = 2'd1;
   localparam logic [1:0] FMT_32 = 2'd2;

   // Input item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // Effective frame settings
   typedef struct packed {
      logic [COL_BITS-1:0] width;
      logic [ROW_BITS-1:0] height;
      logic [31:0]         mask;
   } cfg_type;

   // One classified item: a pixel value and where its results go
   typedef struct packed {
      logic [31:0]         pixel;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                first_col;
      logic                last_col;
   } entry_type;

endpackage
`default_nettype wire

// File: design/rbp_front.sv
// Front part: position tracking, line buffer access and item classification.
`default_nettype none
module rbp_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               restart,
   input  wire rbp_pkg::cfg_type   cfg,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_kind,
   input  wire logic [31:0]        req_pixel_in,
   output logic                    ent_valid,
   output rbp_pkg::entry_type      ent,
   input  wire logic               ent_ready
);
   import rbp_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Position state
   logic [COL_BITS-1:0] in_col_ff, in_col_in;
   logic [ROW_BITS-1:0] in_row_ff, in_row_in;
   logic [COL_BITS-1:0] drain_pos_ff, drain_pos_in;
   logic                drain_active_ff, drain_active_in;
   logic                drain_second_ff, drain_second_in;

   // Stage register toward the queue
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_use_pix_ff, s1_use_pix_in;
   logic [31:0]         s1_pix_ff, s1_pix_in;
   logic [ROW_BITS-1:0] s1_row_ff, s1_row_in;
   logic [COL_BITS-1:0] s1_col_ff, s1_col_in;
   logic                s1_first_ff, s1_first_in;
   logic                s1_last_ff, s1_last_in;

   // Line buffer
   logic [PIXEL_BITS-1:0] line_store_ff [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   logic                accept;
   logic                is_pix;
   logic                op_ok;
   logic                take;
   logic [31:0]         pix;
   logic [COL_BITS-1:0] w_m1;
   logic [COL_BITS-1:0] w_p1;
   logic [COL_BITS-1:0] pix_c;
   logic [COL_BITS-1:0] drain_col;
   logic [COL_BITS-1:0] drain_c0;
   logic [COL_BITS-1:0] drain_c;
   logic [COL_BITS-1:0] col_next;
   logic [ROW_BITS-1:0] row_next;
   logic [COL_BITS-1:0] pos_next;
   logic [AW-1:0]       mem_addr;
   logic                mem_we;

   // Handshake: stall only when the staged item cannot move on
   assign req_full = s1_valid_ff && !ent_ready;
   assign accept   = req_push && !req_full;
   assign is_pix   = (req_kind == KIND_PIXEL);
   assign op_ok    = is_pix ? !drain_active_ff : drain_active_ff;
   assign take     = accept && op_ok;

   // Column selection for both item kinds
   assign pix       = req_pixel_in & cfg.mask;
   assign w_m1      = cfg.width - COL_BITS'(1);
   assign w_p1      = cfg.width + COL_BITS'(1);
   assign pix_c     = (in_col_ff >= cfg.width) ? w_m1 : in_col_ff;
   assign drain_col = (drain_pos_ff > w_p1) ? w_p1 : drain_pos_ff;
   assign drain_c0  = (drain_col == '0) ? '0 : drain_col - COL_BITS'(1);
   assign drain_c   = (drain_c0 >= cfg.width) ? w_m1 : drain_c0;
   assign mem_addr  = AW'(is_pix ? pix_c : drain_c);
   assign mem_we    = take && is_pix;

   assign col_next = pix_c + COL_BITS'(1);
   assign row_next = in_row_ff + ROW_BITS'(1);
   assign pos_next = drain_col + COL_BITS'(1);

   // Position and drain counters
   always_comb begin
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      drain_pos_in    = drain_pos_ff;
      drain_active_in = drain_active_ff;
      drain_second_in = drain_second_ff;
      if (restart) begin
         in_col_in       = '0;
         in_row_in       = '0;
         drain_pos_in    = '0;
         drain_active_in = 1'b0;
         drain_second_in = 1'b0;
      end else if (take && is_pix) begin
         if (col_next >= cfg.width) begin
            in_col_in = '0;
            if (row_next >= cfg.height) begin
               in_row_in       = '0;
               drain_active_in = 1'b1;
               drain_second_in = 1'b0;
               drain_pos_in    = '0;
            end else begin
               in_row_in = row_next;
            end
         end else begin
            in_col_in = col_next;
         end
      end else if (take) begin
         if (pos_next > w_p1) begin
            drain_pos_in = '0;
            if (drain_second_ff) begin
               drain_active_in = 1'b0;
               drain_second_in = 1'b0;
            end else begin
               drain_second_in = 1'b1;
            end
         end else begin
            drain_pos_in = pos_next;
         end
      end
   end

   // Classification of the accepted item
   always_comb begin
      s1_valid_in   = take ? 1'b1 : (s1_valid_ff && !ent_ready);
      s1_use_pix_in = is_pix && (in_row_ff == '0);
      s1_pix_in     = pix;
      if (is_pix) begin
         s1_row_in   = in_row_ff;
         s1_col_in   = col_next;
         s1_first_in = (pix_c == '0);
         s1_last_in  = (pix_c == w_m1);
      end else begin
         s1_row_in   = cfg.height + ROW_BITS'(drain_second_ff);
         s1_col_in   = drain_col;
         s1_first_in = 1'b0;
         s1_last_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         drain_pos_ff    <= '0;
         drain_active_ff <= 1'b0;
         drain_second_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         drain_pos_ff    <= drain_pos_in;
         drain_active_ff <= drain_active_in;
         drain_second_ff <= drain_second_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_use_pix_ff <= s1_use_pix_in;
         s1_pix_ff     <= s1_pix_in;
         s1_row_ff     <= s1_row_in;
         s1_col_ff     <= s1_col_in;
         s1_first_ff   <= s1_first_in;
         s1_last_ff    <= s1_last_in;
      end
   end

   // Line buffer: read old value, then overwrite at the same column
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_ff[mem_addr] <= pix[PIXEL_BITS-1:0];
      end
      if (take) begin
         rd_data_ff <= line_store_ff[mem_addr];
      end
   end

   // Item toward the queue
   assign ent_valid     = s1_valid_ff;
   assign ent.pixel     = s1_use_pix_ff ? s1_pix_ff : 32'(rd_data_ff);
   assign ent.row       = s1_row_ff;
   assign ent.col       = s1_col_ff;
   assign ent.first_col = s1_first_ff;
   assign ent.last_col  = s1_last_ff;

endmodule
`default_nettype wire

// File: design/rbp_queue.sv
// Short item queue between the front and back parts.
`default_nettype none
module rbp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rbp_pkg::entry_type din,
   output logic                    full,
   input  wire logic               pop,
   output rbp_pkg::entry_type      dout,
   output logic                    empty
);
   import rbp_pkg::*;

   entry_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

// File: design/rbp_back.sv
// Back part: expands each queued item into its padded results.
`default_nettype none
module rbp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rbp_pkg::cfg_type   cfg,
   input  wire logic               q_empty,
   input  wire rbp_pkg::entry_type q_head,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [31:0]             rsp_pixel_out,
   output logic [10:0]             rsp_out_col,
   output logic [12:0]             rsp_out_row,
   output logic                    rsp_row_end,
   output logic                    rsp_frame_end
);
   import rbp_pkg::*;

   // Which result of the head item goes next
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_MID   = 2'd1;
   localparam logic [1:0] PH_RIGHT = 2'd2;

   logic [1:0]          phase_ff, phase_in;
   logic [1:0]          phase_next;
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         pixel_ff;
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_ff;
   logic                row_end_ff;
   logic                frame_end_ff;

   logic                load;
   logic                last_of_item;
   logic [COL_BITS-1:0] emit_col;
   logic [COL_BITS-1:0] w_p1;
   logic                emit_row_end;
   logic                emit_frame_end;

   assign w_p1 = cfg.width + COL_BITS'(1);
   assign load = !q_empty && (!out_valid_ff || rsp_pop);

   // Result selection: left pad, own column, right pad
   always_comb begin
      emit_col     = q_head.col;
      phase_next   = PH_START;
      last_of_item = 1'b1;
      case (phase_ff)
         PH_START: begin
            if (q_head.first_col) begin
               emit_col     = '0;
               phase_next   = PH_MID;
               last_of_item = 1'b0;
            end else if (q_head.last_col) begin
               phase_next   = PH_RIGHT;
               last_of_item = 1'b0;
            end
         end
         PH_MID: begin
            if (q_head.last_col) begin
               phase_next   = PH_RIGHT;
               last_of_item = 1'b0;
            end
         end
         PH_RIGHT: begin
            emit_col = w_p1;
         end
         default: begin
            emit_col = q_head.col;
         end
      endcase
   end

   assign emit_row_end   = (emit_col == w_p1);
   assign emit_frame_end = emit_row_end && (q_head.row == cfg.height + ROW_BITS'(1));
   assign q_pop          = load && last_of_item;
   assign phase_in       = load ? phase_next : phase_ff;
   assign out_valid_in   = load ? 1'b1 : (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff     <= q_head.pixel;
         col_ff       <= emit_col;
         row_ff       <= q_head.row;
         row_end_ff   <= emit_row_end;
         frame_end_ff <= emit_frame_end;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_pixel_out = pixel_ff;
   assign rsp_out_col   = col_ff[10:0];
   assign rsp_out_row   = row_ff[12:0];
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule
`default_nettype wire

// File: design/replicate_border_pad.sv
// Items are staged, queued and registered at the output. Throughput: one item per
// cycle in while the queue has room, one result per cycle out while popped; a pixel
// in the first or last source column gives two results, three when the width is
// one. The single-port line buffer is read by each item and written by each pixel.
// Reset (synchronous): counters, queue and output cleared, registers to defaults;
// the line buffer keeps its contents and is always written before it is read.
`default_nettype none
module replicate_border_pad #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int PIXEL_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [rbp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [rbp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_kind,
   input  wire logic [31:0]                         req_pixel_in,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [31:0]                              rsp_pixel_out,
   output logic [10:0]                              rsp_out_col,
   output logic [12:0]                              rsp_out_row,
   output logic                                     rsp_row_end,
   output logic                                     rsp_frame_end
);
   import rbp_pkg::*;

   logic [10:0] src_width_ff, src_width_in;
   logic [12:0] src_height_ff, src_height_in;
   logic [1:0]  pixel_format_ff, pixel_format_in;
   logic        restart;
   cfg_type     cfg;
   logic [31:0] width_mask;

   logic        ent_valid;
   entry_type   ent;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   entry_type   q_head;

   // Configuration registers
   always_comb begin
      src_width_in    = src_width_ff;
      src_height_in   = src_height_ff;
      pixel_format_in = pixel_format_ff;
      restart         = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH: begin
               src_width_in = csr_wdata[10:0];
               restart      = 1'b1;
            end
            CSR_SRC_HEIGHT: begin
               src_height_in = csr_wdata;
               restart       = 1'b1;
            end
            CSR_PIXEL_FORMAT: begin
               pixel_format_in = csr_wdata[1:0];
               restart         = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= 11'd1;
         src_height_ff   <= 13'd1;
         pixel_format_ff <= FMT_32;
      end else begin
         src_width_ff    <= src_width_in;
         src_height_ff   <= src_height_in;
         pixel_format_ff <= pixel_format_in;
      end
   end

   // Effective frame size and pixel mask
   assign width_mask = 32'((64'd1 << PIXEL_BITS) - 64'd1);

   always_comb begin
      if (src_width_ff == '0) begin
         cfg.width = COL_BITS'(1);
      end else if (32'(src_width_ff) > MAX_WIDTH) begin
         cfg.width = COL_BITS'(MAX_WIDTH);
      end else begin
         cfg.width = COL_BITS'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         cfg.height = ROW_BITS'(1);
      end else if (32'(src_height_ff) > MAX_HEIGHT) begin
         cfg.height = ROW_BITS'(MAX_HEIGHT);
      end else begin
         cfg.height = ROW_BITS'(src_height_ff);
      end
      case (pixel_format_ff)
         FMT_8:   cfg.mask = width_mask & 32'h0000_00FF;
         FMT_16:  cfg.mask = width_mask & 32'h0000_FFFF;
         default: cfg.mask = width_mask;
      endcase
   end

   rbp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .cfg          (cfg),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_kind     (req_kind),
      .req_pixel_in (req_pixel_in),
      .ent_valid    (ent_valid),
      .ent          (ent),
      .ent_ready    (!q_full)
   );

   rbp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (ent_valid),
      .din   (ent),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_head),
      .empty (q_empty)
   );

   rbp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

`ifndef ASSERT_OFF
   // Frame end only ever on the last column of a row
   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_row_end)
      else $error("frame_end without row_end");

   // Output column never beyond the right pad column
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (COL_BITS'(rsp_out_col) <= cfg.width + COL_BITS'(1)))
      else $error("output column out of range");

   // Output row never beyond the bottom pad row
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (ROW_BITS'(rsp_out_row) <= cfg.height + ROW_BITS'(1)))
      else $error("output row out of range");
`endif

endmodule
`default_nettype wire

// File: sim/tb_replicate_border_pad.sv
// Self-checking testbench for replicate_border_pad: queued driver, predictor and monitor.
`default_nettype none
module tb_replicate_border_pad;
   import rbp_pkg::*;

   localparam int LINE_LEN      = 1024;
   localparam int ROWS_MAX      = 4096;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 120;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 65;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {GAPS_RECV_HEAVY, GAPS_SEND_HEAVY, GAPS_NONE} gap_mode_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] pixel;
   } src_item_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic [10:0] col;
      logic [12:0] row;
      logic        row_end;
      logic        frame_end;
   } pad_pixel_type;

   // DUT connections
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_kind = KIND_PIXEL;
   logic [31:0] req_pixel_in = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic [10:0] rsp_out_col;
   logic [12:0] rsp_out_row;
   logic        rsp_row_end;
   logic        rsp_frame_end;

   replicate_border_pad dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_full(req_full), .req_kind(req_kind),
      .req_pixel_in(req_pixel_in),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_pixel_out(rsp_pixel_out),
      .rsp_out_col(rsp_out_col), .rsp_out_row(rsp_out_row),
      .rsp_row_end(rsp_row_end), .rsp_frame_end(rsp_frame_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // Testbench bookkeeping
   src_item_type  src_items[$];
   pad_pixel_type pad_pixels_due[$];
   gap_mode_type  gap_mode = GAPS_NONE;
   int         error_count = 0;
   int         stim_count = 0;
   int         hold_requests = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         cycle_count = 0;

   // Predictor state: registers, line buffer and frame position
   logic [10:0] cfg_width;
   logic [12:0] cfg_height;
   logic [1:0]  cfg_format;
   logic [31:0] line_buf [LINE_LEN];
   logic [10:0] col_pos;
   logic [12:0] row_pos;
   logic [10:0] drain_col;
   logic        draining;
   logic        drain_last;

   function automatic int frame_width();
      int w;
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > LINE_LEN) w = LINE_LEN;
      return w;
   endfunction

   function automatic int frame_height();
      int h;
      h = cfg_height;
      if (h < 1) h = 1;
      if (h > ROWS_MAX) h = ROWS_MAX;
      return h;
   endfunction

   function automatic logic [31:0] format_mask();
      case (cfg_format)
         FMT_8:   return 32'h0000_00FF;
         FMT_16:  return 32'h0000_FFFF;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic restart_frame();
      col_pos    = '0;
      row_pos    = '0;
      drain_col  = '0;
      draining   = 1'b0;
      drain_last = 1'b0;
   endtask

   task automatic apply_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_SRC_WIDTH:    cfg_width  = val[10:0];
         CSR_SRC_HEIGHT:   cfg_height = val[12:0];
         CSR_PIXEL_FORMAT: cfg_format = val[1:0];
         default:          return;
      endcase
      restart_frame();
   endtask

   task automatic emit_pixel(logic [31:0] v, int col, int row, int w, int h);
      pad_pixel_type p;
      p.pixel     = v & format_mask();
      p.col       = 11'(col);
      p.row       = 13'(row);
      p.row_end   = (col == w + 1);
      p.frame_end = (col == w + 1) && (row == h + 1);
      pad_pixels_due.push_back(p);
   endtask

   // Padded pixels caused by one accepted item
   task automatic predict_padding(src_item_type it);
      int w, h, c, col, row;
      logic [31:0] pix, v;
      w = frame_width();
      h = frame_height();
      if (it.kind == KIND_PIXEL) begin
         if (draining) return;
         pix = it.pixel & format_mask();
         c = col_pos;
         if (c >= w) c = w - 1;
         // top pad row comes straight from the input, later rows from the buffer
         v = (row_pos == 0) ? pix : line_buf[c];
         line_buf[c] = pix;
         if (c == 0) emit_pixel(v, 0, row_pos, w, h);
         emit_pixel(v, c + 1, row_pos, w, h);
         if (c == w - 1) emit_pixel(v, w + 1, row_pos, w, h);
         col_pos = 11'(c + 1);
         if (col_pos >= w) begin
            col_pos = '0;
            row_pos = row_pos + 1;
            if (row_pos >= h) begin
               row_pos    = '0;
               draining   = 1'b1;
               drain_last = 1'b0;
               drain_col  = '0;
            end
         end
      end else begin
         if (!draining) return;
         col = drain_col;
         if (col > w + 1) col = w + 1;
         c = (col == 0) ? 0 : col - 1;
         if (c >= w) c = w - 1;
         row = h + (drain_last ? 1 : 0);
         emit_pixel(line_buf[c], col, row, w, h);
         drain_col = 11'(col + 1);
         if (drain_col > w + 1) begin
            drain_col = '0;
            if (drain_last) begin
               draining   = 1'b0;
               drain_last = 1'b0;
            end else begin
               drain_last = 1'b1;
            end
         end
      end
   endtask

   function automatic bit sender_gap();
      case (gap_mode)
         GAPS_RECV_HEAVY: return $urandom_range(99) < 10;
         GAPS_SEND_HEAVY: return $urandom_range(99) < 67;
         default:         return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_gap();
      case (gap_mode)
         GAPS_RECV_HEAVY: return $urandom_range(99) < 67;
         GAPS_SEND_HEAVY: return $urandom_range(99) < 10;
         default:         return 1'b0;
      endcase
   endfunction

   // Driver: offers the oldest pending item, holds it while the block is full
   always @(posedge clock) begin : drive_src
      logic offer;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_padding(src_items[0]);
            src_items.pop_front();
         end
         if (!(req_push && req_full)) begin
            offer = (src_items.size() != 0) && !sender_gap();
            req_push <= offer;
            if (offer) begin
               req_kind     <= src_items[0].kind;
               req_pixel_in <= src_items[0].pixel;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Monitor: pops results and compares them with the oldest prediction
   always @(posedge clock) begin : watch_rsp
      pad_pixel_type due;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pad_pixels_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual pixel %0h col %0d row %0d",
                        $time, rsp_pixel_out, rsp_out_col, rsp_out_row);
               error_count++;
            end else begin
               due = pad_pixels_due.pop_front();
               check_field("pixel_out", due.pixel, rsp_pixel_out);
               check_field("out_col", 32'(due.col), 32'(rsp_out_col));
               check_field("out_row", 32'(due.row), 32'(rsp_out_row));
               check_field("row_end", 32'(due.row_end), 32'(rsp_row_end));
               check_field("frame_end", 32'(due.frame_end), 32'(rsp_frame_end));
            end
         end
         // long hold-off on request, so the block backs up into its input
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !receiver_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_item(logic kind, logic [31:0] pixel);
      src_item_type it;
      it.kind  = kind;
      it.pixel = pixel;
      src_items.push_back(it);
   endtask

   function automatic logic [31:0] rand_pixel();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Block idle: every item taken, every result in, pipeline flushed
   task automatic wait_idle();
      while (src_items.size() != 0 || pad_pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One frame of w x h pixels and its drain ticks; cut >= 0 abandons it early.
   // Ignored items are mixed in now and then.
   task automatic queue_frame(int w, int h, int cut);
      for (int i = 0; i < w * h; i++) begin
         if (cut >= 0 && i == cut) return;
         if ($urandom_range(19) == 0) queue_item(KIND_DRAIN, $urandom);
         queue_item(KIND_PIXEL, rand_pixel());
         stim_count++;
      end
      for (int i = 0; i < 2 * (w + 2); i++) begin
         if ($urandom_range(19) == 0) queue_item(KIND_PIXEL, rand_pixel());
         queue_item(KIND_DRAIN, $urandom);
         stim_count++;
      end
   endtask

   task automatic run_frame(logic [12:0] wv, logic [12:0] hv, logic [12:0] fv, int cut);
      wait_idle();
      write_csr(CSR_SRC_WIDTH, wv);
      write_csr(CSR_SRC_HEIGHT, hv);
      write_csr(CSR_PIXEL_FORMAT, fv);
      queue_frame(frame_width(), frame_height(), cut);
   endtask

   task automatic random_frame();
      int w, h, cut;
      w = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if ($urandom_range(15) == 0) w = 0;
      if ($urandom_range(15) == 0) h = 0;
      cut = ($urandom_range(99) < 15) ? $urandom_range(0, w * h) : -1;
      // spare width bits above bit 10 must be dropped
      run_frame(13'(w) | (13'($urandom_range(3)) << 11), 13'(h),
                {11'($urandom), 2'($urandom_range(3))}, cut);
   endtask

   initial begin : stimulus
      int stop_at;
      cfg_width  = 11'd1;
      cfg_height = 13'd1;
      cfg_format = FMT_32;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: default 1x1 frame, drain ticks out of place
      queue_item(KIND_DRAIN, 32'hFFFF_FFFF);
      queue_item(KIND_PIXEL, 32'hFFFF_FFFF);
      repeat (3) queue_item(KIND_DRAIN, 32'h0);
      queue_item(KIND_PIXEL, 32'h0);
      repeat (3) queue_item(KIND_DRAIN, 32'h0);
      queue_item(KIND_DRAIN, 32'h0);
      wait_idle();

      // Directed: unused register index leaves the frame running
      write_csr(CSR_SRC_WIDTH, 13'h1802);
      write_csr(CSR_SRC_HEIGHT, 13'd2);
      write_csr(CSR_PIXEL_FORMAT, {11'h7FF, FMT_16});
      queue_item(KIND_PIXEL, 32'hA5A5_5A5A);
      wait_idle();
      write_csr(CSR_UNUSED, 13'h1FFF);
      queue_item(KIND_PIXEL, 32'h8000_0001);
      queue_item(KIND_PIXEL, 32'h7FFF_FFFE);
      wait_idle();

      // Directed: mid-frame write restarts, zero height clamps to one, 8-bit pixels
      write_csr(CSR_SRC_HEIGHT, 13'd0);
      write_csr(CSR_PIXEL_FORMAT, 13'(FMT_8));
      queue_item(KIND_PIXEL, 32'h1234_5678);
      queue_item(KIND_PIXEL, 32'hFFFF_FF00);
      repeat (8) queue_item(KIND_DRAIN, 32'hFFFF_FFFF);

      // Random frames, receiver mostly stalling
      gap_mode = GAPS_RECV_HEAVY;
      stop_at = stim_count + PHASE_ITEMS;
      while (stim_count < stop_at) random_frame();

      // Random frames, sender mostly idle
      gap_mode = GAPS_SEND_HEAVY;
      stop_at = stim_count + PHASE_ITEMS;
      while (stim_count < stop_at) random_frame();

      // No idling; first frame backs up behind a long receiver hold-off
      gap_mode = GAPS_NONE;
      wait_idle();
      hold_requests++;
      run_frame(13'd6, 13'd4, 13'(FMT_32), -1);
      stop_at = stim_count + PHASE_ITEMS;
      while (stim_count < stop_at) random_frame();

      // Largest sizes, cut short: clamped width and height
      run_frame(13'h1FFF, 13'd3, 13'(FMT_32), 40);
      run_frame(13'd1024, 13'd4096, 13'(FMT_8), 20);
      run_frame(13'd1, 13'h1FFF, 13'd3, 25);
      run_frame(13'd1, 13'd4096, 13'(FMT_16), 30);

      wait_idle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
